@@ sv/phl_pkg.sv @@
// Package for the packet header L3/L4 locator: parse phases, status codes,
// the per-header parse state record and the per-byte parse functions.
// No dependencies.
package phl_pkg;

  localparam int MAX_HEADER_BYTES_DEF = 256;
  localparam int POS_CMP_W = 13;

  typedef enum logic [3:0] {
    PH_FIRST   = 4'd0,
    PH_MAC     = 4'd1,
    PH_TAG     = 4'd2,
    PH_LLC     = 4'd3,
    PH_SNAP    = 4'd4,
    PH_IPV4    = 4'd5,
    PH_IPV6    = 4'd6,
    PH_EXT     = 4'd7,
    PH_EXT_LEN = 4'd8,
    PH_UNKNOWN = 4'd9,
    PH_DONE    = 4'd10
  } phase_t;

  localparam logic [1:0] ST_IPV4    = 2'd0;
  localparam logic [1:0] ST_IPV6    = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  localparam logic [1:0] FR_ETH  = 2'd0;
  localparam logic [1:0] FR_IPV4 = 2'd1;
  localparam logic [1:0] FR_IPV6 = 2'd2;

  localparam logic [15:0] ET_VLAN  = 16'h8100;
  localparam logic [15:0] ET_QINQ  = 16'h88A8;
  localparam logic [15:0] ET_Q9100 = 16'h9100;
  localparam logic [15:0] ET_Q9200 = 16'h9200;
  localparam logic [15:0] ET_Q9300 = 16'h9300;
  localparam logic [15:0] ET_IPV4  = 16'h0800;
  localparam logic [15:0] ET_IPV6  = 16'h86DD;
  localparam logic [15:0] ET_MAX_LEN = 16'd1500;

  localparam logic [23:0] LLC_SNAP = 24'hAAAA03;
  localparam logic [15:0] LLC_ISO  = 16'h0606;

  localparam logic [7:0] NH_HOP   = 8'd0;
  localparam logic [7:0] NH_ROUTE = 8'd43;
  localparam logic [7:0] NH_AUTH  = 8'd51;
  localparam logic [7:0] NH_DEST  = 8'd60;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] ether_type;
    logic [7:0]  next_header;
    logic [7:0]  network_start;
    logic [11:0] transport_start;
    logic [23:0] recent_bytes;
    logic [1:0]  verdict;
  } parse_state_t;

  localparam parse_state_t STATE_CLEAR = '{
    phase: PH_FIRST,
    ether_type: 16'h0,
    next_header: 8'h0,
    network_start: 8'h0,
    transport_start: 12'h0,
    recent_bytes: 24'h0,
    verdict: 2'd0
  };

  function automatic logic skippable(input logic [7:0] nh);
    return (nh == NH_HOP) || (nh == NH_ROUTE) || (nh == NH_AUTH) || (nh == NH_DEST);
  endfunction

  function automatic parse_state_t finish(input parse_state_t s, input logic [1:0] v);
    parse_state_t t;
    t = s;
    t.verdict = v;
    t.phase = PH_DONE;
    return t;
  endfunction

  function automatic parse_state_t dispatch_ip(input parse_state_t s);
    parse_state_t t;
    t = s;
    if (t.ether_type == ET_IPV4 || t.ether_type == ET_IPV6) begin
      if (t.transport_start > 12'd255) begin
        t = finish(t, ST_BAD);
      end else begin
        t.network_start = t.transport_start[7:0];
        t.phase = (t.ether_type == ET_IPV4) ? PH_IPV4 : PH_IPV6;
      end
    end else begin
      t.phase = PH_UNKNOWN;
    end
    return t;
  endfunction

  function automatic parse_state_t dispatch_eth(input parse_state_t s);
    parse_state_t t;
    t = s;
    if (t.ether_type == ET_VLAN || t.ether_type == ET_QINQ || t.ether_type == ET_Q9100 ||
        t.ether_type == ET_Q9200 || t.ether_type == ET_Q9300) begin
      t.phase = PH_TAG;
    end else if (t.ether_type <= ET_MAX_LEN) begin
      t.phase = PH_LLC;
    end else begin
      t = dispatch_ip(t);
    end
    return t;
  endfunction

  function automatic parse_state_t consume(input parse_state_t s,
                                           input logic [POS_CMP_W-1:0] p,
                                           input logic [7:0] b);
    parse_state_t t;
    logic [POS_CMP_W-1:0] ts;
    logic [POS_CMP_W-1:0] ns;
    t = s;
    ts = POS_CMP_W'(s.transport_start);
    ns = POS_CMP_W'(s.network_start);
    t.recent_bytes = {s.recent_bytes[15:0], b};
    case (s.phase)
      PH_MAC: begin
        if (p == POS_CMP_W'(13)) begin
          t.ether_type = t.recent_bytes[15:0];
          t.transport_start = 12'd14;
          t = dispatch_eth(t);
        end
      end
      PH_TAG: begin
        if (p == ts + POS_CMP_W'(3)) begin
          t.ether_type = t.recent_bytes[15:0];
          t.transport_start = s.transport_start + 12'd4;
          t = dispatch_eth(t);
        end
      end
      PH_LLC: begin
        if (p == ts + POS_CMP_W'(2)) begin
          if (t.recent_bytes == LLC_SNAP) begin
            t.phase = PH_SNAP;
          end else if (t.recent_bytes[23:8] == LLC_ISO && b[0]) begin
            t.transport_start = s.transport_start + 12'd3;
            t.ether_type = ET_IPV4;
            t = dispatch_ip(t);
          end else begin
            t = finish(t, ST_BAD);
          end
        end
      end
      PH_SNAP: begin
        if (p == ts + POS_CMP_W'(5) && t.recent_bytes != 24'h0) begin
          t = finish(t, ST_BAD);
        end else if (p == ts + POS_CMP_W'(7)) begin
          t.ether_type = t.recent_bytes[15:0];
          t.transport_start = s.transport_start + 12'd8;
          t = dispatch_ip(t);
        end
      end
      PH_IPV4: begin
        if (p == ns) begin
          if (b[7:4] != 4'd4 || b[3:0] < 4'd5) begin
            t = finish(t, ST_BAD);
          end else begin
            t.transport_start = 12'(s.network_start) + 12'({b[3:0], 2'b00});
          end
        end else if (p == ns + POS_CMP_W'(9)) begin
          t.next_header = b;
        end else if (p == ns + POS_CMP_W'(19)) begin
          t = finish(t, ST_IPV4);
        end
      end
      PH_IPV6: begin
        if (p == ns) begin
          if (b[7:4] != 4'd6) begin
            t = finish(t, ST_BAD);
          end
        end else if (p == ns + POS_CMP_W'(6)) begin
          t.next_header = b;
          t.transport_start = 12'(s.network_start) + 12'd40;
          if (skippable(b)) begin
            t.phase = PH_EXT;
          end else begin
            t = finish(t, ST_IPV6);
          end
        end
      end
      PH_EXT: begin
        if (p == ts) begin
          t.phase = PH_EXT_LEN;
        end
      end
      PH_EXT_LEN: begin
        t.next_header = s.recent_bytes[7:0];
        t.transport_start = s.transport_start + {(9'(b) + 9'd1), 3'b000};
        if (skippable(s.recent_bytes[7:0])) begin
          t.phase = PH_EXT;
        end else begin
          t = finish(t, ST_IPV6);
        end
      end
      default: begin
      end
    endcase
    return t;
  endfunction

endpackage

@@ sv/packet_header_l3_l4_locator_core.sv @@
// Top level of the packet header L3/L4 locator: input register, per-byte
// parse logic and a result register on a streaming interface.
// Depends on phl_pkg.
//
//   channel  | direction | tdata                                   | tuser / tlast
//   s_axis   | in        | data_byte[7:0]                          | framing / last_byte
//   m_axis   | out       | status, ip_protocol, ip_off, l4_off     | none
//
// One header byte is taken per cycle while no last byte waits on a held result;
// each byte waits in the input register, and its state update and any result are
// made when it advances; its last byte's advance registers the result on m_axis.
// Reset clears the parse state, the byte counter and both valid flags.
// A held result stalls only a following last byte; other bytes keep flowing.
module packet_header_l3_l4_locator_core
  import phl_pkg::*;
#(
  parameter int MAX_HEADER_BYTES = MAX_HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  input  logic [1:0]  s_axis_tuser,   // [1:0] framing
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [1:0] parse_status, [9:2] ip_protocol,
                                      // [17:10] ip_offset, [29:18] transport_offset
);

  localparam int PW = $clog2(MAX_HEADER_BYTES + 1);

  logic         in_valid;
  logic [7:0]   in_byte;
  logic         in_last;
  logic [1:0]   in_proto;
  logic         adv;

  parse_state_t state;
  parse_state_t state_next;
  parse_state_t work;
  logic [PW-1:0] byte_position;
  logic [PW-1:0] byte_position_next;
  logic [PW-1:0] len;
  logic          in_range;
  logic [1:0]    status;
  logic [31:0]   result;

  assign adv = in_valid && (!in_last || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte  <= s_axis_tdata;
      in_last  <= s_axis_tlast;
      in_proto <= s_axis_tuser;
    end
  end

  always_comb begin
    work = state;
    in_range = byte_position < PW'(MAX_HEADER_BYTES);
    if (in_range) begin
      if (byte_position == '0) begin
        work.transport_start = 12'd0;
        case (in_proto)
          FR_ETH: begin
            work.phase = PH_MAC;
          end
          FR_IPV4: begin
            work.ether_type = ET_IPV4;
            work = dispatch_ip(work);
          end
          FR_IPV6: begin
            work.ether_type = ET_IPV6;
            work = dispatch_ip(work);
          end
          default: begin
            work = finish(work, ST_UNKNOWN);
          end
        endcase
      end
      work = consume(work, POS_CMP_W'(byte_position), in_byte);
    end
    len = byte_position + PW'(in_range);

    if (work.phase == PH_DONE) begin
      status = work.verdict;
    end else if (work.phase == PH_UNKNOWN) begin
      status = (len < PW'(20)) ? ST_BAD : ST_UNKNOWN;
    end else if (work.phase == PH_EXT) begin
      status = ST_IPV6;
    end else begin
      status = ST_BAD;
    end

    if (status == ST_IPV4 || status == ST_IPV6) begin
      result = {2'b00, work.transport_start, work.network_start, work.next_header, status};
    end else begin
      result = {30'h0, status};
    end

    if (in_last) begin
      state_next = STATE_CLEAR;
      byte_position_next = '0;
    end else begin
      state_next = work;
      byte_position_next = len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_CLEAR;
      byte_position <= '0;
    end else if (adv) begin
      state <= state_next;
      byte_position <= byte_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv && in_last) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (adv && in_last) begin
      m_axis_tdata <= result;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    byte_position <= PW'(MAX_HEADER_BYTES))
    else $error("byte counter ran past the header bound");

  assert property (@(posedge clk) disable iff (rst)
    adv && in_last |=> m_axis_tvalid && byte_position == '0)
    else $error("last byte did not yield a result and a cleared counter");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[1:0] == ST_BAD || m_axis_tdata[1:0] == ST_UNKNOWN)
      |-> m_axis_tdata[31:2] == 30'h0)
    else $error("failed parse carries nonzero offsets");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1:0] == ST_IPV4
      |-> m_axis_tdata[29:18] >= 12'(m_axis_tdata[17:10]) + 12'd20)
    else $error("IPv4 transport offset lies inside the minimum header");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready && in_valid && in_last |-> !s_axis_tready)
    else $error("input taken while a last byte waits on a held result");

endmodule
